FILE: hw/rtl/pcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcc_pkg
// Shared types, codes and arithmetic helpers of the pointwise convolution MAC.
// ----------------------------------------------------------------------------
package pcc_pkg;

	localparam int MAX_CHANNELS_DEF = 64;
	localparam int MAX_INPUTS_DEF   = 4;
	localparam int MAX_OUTPUTS_DEF  = 64;

	localparam int CMD_W   = 2;
	localparam int OIDX_W  = 6;
	localparam int IIDX_W  = 8;
	localparam int VAL_W   = 16;
	localparam int ACC_W   = 40;
	localparam int PROD_W  = 32;
	localparam int FRAC_SH = 14;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	localparam logic [CMD_W-1:0] CMD_WEIGHT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_BIAS   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_ACT    = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_INPUT_COUNT        = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNELS_PER_INPUT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_CHANNELS    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BIAS_ENABLE        = 2'd3;

	typedef struct packed {
		logic             valid;
		logic [CMD_W-1:0] cmd;
		logic             wr_ok;
		logic             first;
		logic             last;
	} tok_ctl_t;

	// Round half up from Q18.22 to Q8.8 and saturate to 16 bits.
	function automatic logic signed [VAL_W-1:0] round_sat(input logic [ACC_W-1:0] a);
		logic signed [ACC_W:0] v;
		logic signed [ACC_W:0] q;
		v = $signed({a[ACC_W-1], a}) + $signed((ACC_W+1)'(1 << (FRAC_SH - 1)));
		q = v >>> FRAC_SH;
		if (q > $signed((ACC_W+1)'(32767))) begin
			round_sat = 16'sh7FFF;
		end else if (q < -$signed((ACC_W+1)'(32768))) begin
			round_sat = 16'sh8000;
		end else begin
			round_sat = q[VAL_W-1:0];
		end
	endfunction

endpackage

FILE: hw/rtl/pcc_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcc_in_if
// Request channel carrying loads and activations into the MAC.
// ----------------------------------------------------------------------------
interface pcc_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         command;
	logic [5:0]         out_index;
	logic [7:0]         in_index;
	logic signed [15:0] value;
	logic               tile_end;

	modport source (output valid, command, out_index, in_index, value, tile_end,
		input ready);
	modport sink (input valid, command, out_index, in_index, value, tile_end,
		output ready);
endinterface

FILE: hw/rtl/pcc_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcc_out_if
// Result channel carrying one request per output channel of a pixel.
// ----------------------------------------------------------------------------
interface pcc_out_if;
	logic               valid;
	logic               ready;
	logic [5:0]         out_channel;
	logic signed [15:0] result;
	logic               pixel_last;
	logic               tile_last;

	modport source (output valid, out_channel, result, pixel_last, tile_last,
		input ready);
	modport sink (input valid, out_channel, result, pixel_last, tile_last,
		output ready);
endinterface

FILE: hw/rtl/pointwise_conv_concat_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pointwise_conv_concat_mac
// 1x1 convolution over concatenated input tensors on a chain of MAC cells.
// ----------------------------------------------------------------------------
// Weight loads, bias loads and activations arrive as requests on in_ch and
// travel down a chain of one cell per output channel, one cell per cycle, so
// every cell sees them in arrival order. Loads and activations of a pixel are
// taken one per cycle. After the last activation of a pixel the input is held
// off while the token drains through the chain and the MAC pipeline; the
// results then shift out of the chain on out_ch, one per cycle while the
// receiver takes them, output channel 0 first. A stall on out_ch simply
// holds the current result and the input stays closed until the final result
// of the pixel is taken. Configuration is written through cfg_we, cfg_index
// and cfg_data and restarts the channel count of a partial pixel.
// Reset empties the chain, clears the accumulators and the channel count and
// sets the registers to their defaults; weight and bias stores keep no reset.
// ----------------------------------------------------------------------------
module pointwise_conv_concat_mac import pcc_pkg::*; #(
	parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
	parameter int MAX_INPUTS   = MAX_INPUTS_DEF,
	parameter int MAX_OUTPUTS  = MAX_OUTPUTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	pcc_in_if.sink                in_ch,
	pcc_out_if.source             out_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int ROW_STRIDE = MAX_INPUTS * MAX_CHANNELS;
	localparam int AW    = (ROW_STRIDE > 1) ? $clog2(ROW_STRIDE) : 1;
	localparam int TW    = $clog2(ROW_STRIDE + 1);
	localparam int NINW  = $clog2(MAX_INPUTS + 1);
	localparam int NCHW  = $clog2(MAX_CHANNELS + 1);
	localparam int NOW   = $clog2(MAX_OUTPUTS + 1);
	localparam int OW    = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
	localparam int DRAIN = MAX_OUTPUTS + 4;
	localparam int DW    = $clog2(DRAIN + 1);

	localparam logic [1:0] ST_RUN   = 2'd0;
	localparam logic [1:0] ST_DRAIN = 2'd1;
	localparam logic [1:0] ST_SEND  = 2'd2;

	logic [2:0]     input_count_q;
	logic [6:0]     channels_per_input_q;
	logic [6:0]     output_channels_q;
	logic           bias_enable_q;
	logic [AW-1:0]  chan_pos_q;
	logic [1:0]     state_q;
	logic [DW-1:0]  drain_q;
	logic [OW-1:0]  out_idx_q;
	logic [NOW-1:0] nout_q;
	logic           tile_q;

	logic [NINW-1:0] nin;
	logic [NCHW-1:0] nch;
	logic [NOW-1:0]  nout;
	logic [TW-1:0]   total;
	logic [AW-1:0]   pos;
	logic            first, last;
	logic            in_acc, act_acc, out_acc, out_end;

	tok_ctl_t                ctl_top;
	logic [AW-1:0]           addr_top;

	tok_ctl_t                ctl_c   [MAX_OUTPUTS];
	logic [AW-1:0]           addr_c  [MAX_OUTPUTS];
	logic [OIDX_W-1:0]       oidx_c  [MAX_OUTPUTS];
	logic signed [VAL_W-1:0] value_c [MAX_OUTPUTS];
	logic signed [VAL_W-1:0] res_c   [MAX_OUTPUTS];

	assign nin = (input_count_q == '0) ? NINW'(1) :
		(32'(input_count_q) > MAX_INPUTS) ? NINW'(MAX_INPUTS) : NINW'(input_count_q);
	assign nch = (channels_per_input_q == '0) ? NCHW'(1) :
		(32'(channels_per_input_q) > MAX_CHANNELS) ? NCHW'(MAX_CHANNELS) :
		NCHW'(channels_per_input_q);
	assign nout = (output_channels_q == '0) ? NOW'(1) :
		(32'(output_channels_q) > MAX_OUTPUTS) ? NOW'(MAX_OUTPUTS) :
		NOW'(output_channels_q);
	assign total = TW'(nin) * TW'(nch);

	assign pos   = (TW'(chan_pos_q) >= total) ? '0 : chan_pos_q;
	assign first = (pos == '0);
	assign last  = (TW'(pos) + TW'(1) == total);

	assign in_ch.ready = (state_q == ST_RUN);
	assign in_acc  = in_ch.valid && in_ch.ready;
	assign act_acc = in_acc && in_ch.command == CMD_ACT;
	assign out_acc = out_ch.valid && out_ch.ready;
	assign out_end = (NOW'(out_idx_q) + NOW'(1) == nout_q);

	always_comb begin
		ctl_top.valid = in_acc;
		ctl_top.cmd   = in_ch.command;
		ctl_top.wr_ok = (32'(in_ch.in_index) < ROW_STRIDE);
		ctl_top.first = first;
		ctl_top.last  = last;
		if (in_ch.command == CMD_ACT) begin
			addr_top = pos;
		end else begin
			addr_top = AW'(in_ch.in_index);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			input_count_q        <= 3'd2;
			channels_per_input_q <= 7'd64;
			output_channels_q    <= 7'd64;
			bias_enable_q        <= 1'b1;
			chan_pos_q           <= '0;
			state_q              <= ST_RUN;
			drain_q              <= '0;
			out_idx_q            <= '0;
			nout_q               <= NOW'(1);
			tile_q               <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_INPUT_COUNT:        input_count_q        <= cfg_data[2:0];
					REG_CHANNELS_PER_INPUT: channels_per_input_q <= cfg_data;
					REG_OUTPUT_CHANNELS:    output_channels_q    <= cfg_data;
					REG_BIAS_ENABLE:        bias_enable_q        <= cfg_data[0];
					default: ;
				endcase
				chan_pos_q <= '0;
			end else if (act_acc) begin
				chan_pos_q <= last ? '0 : AW'(TW'(pos) + TW'(1));
			end
			case (state_q)
				ST_RUN: begin
					if (act_acc && last) begin
						state_q   <= ST_DRAIN;
						drain_q   <= DW'(DRAIN);
						out_idx_q <= '0;
						nout_q    <= nout;
						tile_q    <= in_ch.tile_end;
					end
				end
				ST_DRAIN: begin
					if (drain_q == '0) begin
						state_q <= ST_SEND;
					end else begin
						drain_q <= drain_q - DW'(1);
					end
				end
				ST_SEND: begin
					if (out_acc) begin
						if (out_end) begin
							state_q <= ST_RUN;
						end else begin
							out_idx_q <= out_idx_q + OW'(1);
						end
					end
				end
				default: state_q <= ST_RUN;
			endcase
		end
	end

	for (genvar k = 0; k < MAX_OUTPUTS; k++) begin : g_cell
		pcc_cell #(
			.IDX   (k),
			.DEPTH (ROW_STRIDE)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.bias_enable (bias_enable_q),
			.ctl_in      ((k == 0) ? ctl_top : ctl_c[(k == 0) ? 0 : k - 1]),
			.addr_in     ((k == 0) ? addr_top : addr_c[(k == 0) ? 0 : k - 1]),
			.oidx_in     ((k == 0) ? in_ch.out_index : oidx_c[(k == 0) ? 0 : k - 1]),
			.value_in    ((k == 0) ? in_ch.value : value_c[(k == 0) ? 0 : k - 1]),
			.ctl_out     (ctl_c[k]),
			.addr_out    (addr_c[k]),
			.oidx_out    (oidx_c[k]),
			.value_out   (value_c[k]),
			.shift       (out_acc),
			.res_in      ((k == MAX_OUTPUTS - 1) ? '0 :
				res_c[(k == MAX_OUTPUTS - 1) ? k : k + 1]),
			.res_out     (res_c[k])
		);
	end

	assign out_ch.valid       = (state_q == ST_SEND);
	assign out_ch.out_channel = OIDX_W'(out_idx_q);
	assign out_ch.result      = res_c[0];
	assign out_ch.pixel_last  = out_end;
	assign out_ch.tile_last   = out_end && tile_q;

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		TW'(chan_pos_q) < total)
		else $error("channel position beyond the pixel's channel count");

	a_last_closes_input: assert property (@(posedge clk) disable iff (!arst_n)
		act_acc && last |=> !in_ch.ready)
		else $error("input still open after the last activation of a pixel");

	a_end_reopens_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && out_ch.pixel_last |=> in_ch.ready && !out_ch.valid)
		else $error("input not reopened after the final result of a pixel");

	a_tile_on_pixel_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.tile_last |-> out_ch.pixel_last)
		else $error("tile end marked on a result that does not end a pixel");

endmodule

FILE: hw/rtl/pcc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcc_cell
// One output channel: weight row memory, bias, MAC pipeline and result slot.
// ----------------------------------------------------------------------------
module pcc_cell import pcc_pkg::*; #(
	parameter int IDX   = 0,
	parameter int DEPTH = MAX_INPUTS_DEF * MAX_CHANNELS_DEF,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     bias_enable,
	input  tok_ctl_t                 ctl_in,
	input  logic [AW-1:0]            addr_in,
	input  logic [OIDX_W-1:0]        oidx_in,
	input  logic signed [VAL_W-1:0]  value_in,
	output tok_ctl_t                 ctl_out,
	output logic [AW-1:0]            addr_out,
	output logic [OIDX_W-1:0]        oidx_out,
	output logic signed [VAL_W-1:0]  value_out,
	input  logic                     shift,
	input  logic signed [VAL_W-1:0]  res_in,
	output logic signed [VAL_W-1:0]  res_out
);

	tok_ctl_t                ctl_q;
	logic [AW-1:0]           addr_q;
	logic [OIDX_W-1:0]       oidx_q;
	logic signed [VAL_W-1:0] value_q;
	logic signed [VAL_W-1:0] bias_q;
	logic signed [VAL_W-1:0] mem [DEPTH];

	logic                    act_s1, first_s1, last_s1;
	logic signed [VAL_W-1:0] w_s1, a_s1, bias_s1;
	logic                    act_s2, first_s2, last_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [VAL_W-1:0] bias_s2;
	logic [ACC_W-1:0]        acc_q;
	logic                    done_s3;
	logic signed [VAL_W-1:0] res_q;

	logic                    match;
	logic [ACC_W-1:0]        base;

	assign match = ({3'b000, oidx_q} == 9'(IDX));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		addr_q  <= addr_in;
		oidx_q  <= oidx_in;
		value_q <= value_in;
		if (ctl_q.valid && ctl_q.cmd == CMD_BIAS && match) begin
			bias_q <= value_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_q.valid && ctl_q.cmd == CMD_WEIGHT && ctl_q.wr_ok && match) begin
			mem[addr_q] <= value_q;
		end
		w_s1 <= mem[addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_s1  <= 1'b0;
			act_s2  <= 1'b0;
			done_s3 <= 1'b0;
			acc_q   <= '0;
		end else begin
			act_s1  <= ctl_q.valid && ctl_q.cmd == CMD_ACT;
			act_s2  <= act_s1;
			done_s3 <= act_s2 && last_s2;
			if (act_s2) begin
				acc_q <= base + {{(ACC_W-PROD_W){prod_s2[PROD_W-1]}}, prod_s2};
			end
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= ctl_q.first;
		last_s1  <= ctl_q.last;
		a_s1     <= value_q;
		bias_s1  <= bias_q;
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		bias_s2  <= bias_s1;
		prod_s2  <= w_s1 * a_s1;
		if (done_s3) begin
			res_q <= round_sat(acc_q);
		end else if (shift) begin
			res_q <= res_in;
		end
	end

	always_comb begin
		if (!first_s2) begin
			base = acc_q;
		end else if (bias_enable) begin
			base = {{(ACC_W-VAL_W-FRAC_SH){bias_s2[VAL_W-1]}}, bias_s2, {FRAC_SH{1'b0}}};
		end else begin
			base = '0;
		end
	end

	assign ctl_out   = ctl_q;
	assign addr_out  = addr_q;
	assign oidx_out  = oidx_q;
	assign value_out = value_q;
	assign res_out   = res_q;

endmodule
